// File: rtl/dq_pkg.sv
// shared constants, types and index helpers for the circular deque
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_BACK   = 2'd2,
        REQ_POP_FRONT  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - IDX_W'(1);
    endfunction

    // occupancy field keeps the low bits of the count
    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] c);
        logic [OCC_W+CNT_W-1:0] w;
        w = {{OCC_W{1'b0}}, c};
        return w[OCC_W-1:0];
    endfunction

endpackage

// File: rtl/dq_if.sv
// request and response channel interfaces of the circular deque
interface dq_req_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    t_req                     req_type;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, output req_type, output data_in, input ready);
    modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface dq_rsp_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [DATA_W-1:0] front_value;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output front_value,
                    output is_empty, output occupancy, input ready);
    modport sink   (input valid, input status, input front_value,
                    input is_empty, input occupancy, output ready);
endinterface

// File: rtl/dq_ram.sv
// slot store: one write port, one registered read port with write forwarding
module dq_ram (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [dq_pkg::IDX_W-1:0]         i_waddr,
    input  logic signed [dq_pkg::DATA_W-1:0] i_wdata,
    input  logic                             i_re,
    input  logic [dq_pkg::IDX_W-1:0]         i_raddr,
    output logic signed [dq_pkg::DATA_W-1:0] o_rdata
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // a read of the entry written in the same cycle sees the new word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/circular_deque.sv
// circular deque: an accepted request moves to the read state, and its result
// goes to the output register; the front word comes from the slot store
// one request per cycle while results are taken; a held result holds the next
// request until the output register frees up
// reset (synchronous, active low) empties the deque and clears both indices;
// the slot store itself is not cleared
module circular_deque (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);
    import dq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                   r_state;
    logic [IDX_W-1:0]         r_front;
    logic [IDX_W-1:0]         r_back;
    logic [CNT_W-1:0]         r_count;
    t_status                  r_status;

    logic                     r_out_valid;
    t_status                  r_out_status;
    logic signed [DATA_W-1:0] r_out_front;
    logic                     r_out_empty;
    logic [OCC_W-1:0]         r_out_occ;

    logic [IDX_W-1:0]         n_front;
    logic [IDX_W-1:0]         n_back;
    logic [CNT_W-1:0]         n_count;
    t_status                  n_status;
    logic                     w_we;
    logic [IDX_W-1:0]         w_waddr;
    logic signed [DATA_W-1:0] w_rdata;
    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_load;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_load     = (r_state == S_READ) && w_out_free;
    assign i_req.ready = (r_state == S_IDLE) || w_load;
    assign w_accept   = i_req.valid && i_req.ready;

    // index and count update for the request at the port
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = ST_DONE;
        w_we     = 1'b0;
        w_waddr  = '0;
        case (i_req.req_type)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                if (r_count == CNT_FULL) begin
                    n_status = ST_OVERFLOW;
                end else if (r_count == '0) begin
                    n_front = '0;
                    n_back  = '0;
                    n_count = CNT_W'(1);
                    w_we    = 1'b1;
                end else if (i_req.req_type == REQ_PUSH_BACK) begin
                    n_back  = idx_next(r_back);
                    n_count = r_count + CNT_W'(1);
                    w_we    = 1'b1;
                    w_waddr = n_back;
                end else begin
                    n_front = idx_prev(r_front);
                    n_count = r_count + CNT_W'(1);
                    w_we    = 1'b1;
                    w_waddr = n_front;
                end
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (r_count == CNT_W'(1)) begin
                    n_front = '0;
                    n_back  = '0;
                    n_count = '0;
                end else if (i_req.req_type == REQ_POP_BACK) begin
                    n_back  = idx_prev(r_back);
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_front = idx_next(r_front);
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    dq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_req.data_in),
        .i_re    (w_accept),
        .i_raddr (n_front),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_front  <= n_front;
                r_back   <= n_back;
                r_count  <= n_count;
                r_status <= n_status;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_READ;
                    end
                    if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    if (w_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_front  <= (r_count == '0) ? '1 : w_rdata;
                        r_out_empty  <= (r_count == '0);
                        r_out_occ    <= occ_of(r_count);
                        if (!w_accept) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.occupancy   = r_out_occ;

endmodule
